// File: rtl/core/spf_pkg.sv
// Shared sizes, constants and divider handshake types for the string period finder.
// No dependencies; compile first.
package spf_pkg;

  localparam int MAX_LEN     = 1024;
  localparam int ADDR_W      = $clog2(MAX_LEN);
  localparam int LEN_W       = $clog2(MAX_LEN + 1);
  localparam int SYM_W       = 8;
  localparam int PERIOD_W    = 10;
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int DIV_STEPS   = LEN_W;
  localparam int STEP_W      = $clog2(DIV_STEPS + 1);

  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] dividend;
    logic [LEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [LEN_W-1:0] rem;
  } div_rsp_t;

endpackage

// File: rtl/core/spf_if.sv
// Valid/ready channel interfaces: input symbols and period results.
// Depends on spf_pkg.
interface spf_sym_if import spf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface spf_res_if import spf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                periodic;
  logic [PERIOD_W-1:0] period;
  logic                overflow;
  logic                final_res;

  modport source (output valid, output periodic, output period, output overflow,
                  output final_res, input ready);
  modport sink   (input valid, input periodic, input period, input overflow,
                  input final_res, output ready);
endinterface

// File: rtl/core/string_period_finder.sv
// String period finder top level: KMP failure table in block memories, period search.
// Depends on spf_pkg, spf_sym_if / spf_res_if and spf_divrem.
//
// Feed a string one byte per transaction on sym_ch, with last set on its final
// byte. Each byte is stored in a text memory and the KMP failure table grows in
// a prefix memory, both addressed by the byte position. The first byte of a
// string, and any byte arriving with the store full, is settled on acceptance
// with no compare; other bytes go through a text read and a compare, plus a
// prefix read and a text read per failure link followed. After the final byte
// the block checks periodicity (p = n - lps) with an iterative remainder unit
// of LEN_W steps, then tries each multiple of p up to n/2 with the same unit,
// and emits each divisor found as one result transaction in rising order, up
// to MAX_RESULTS results; final_res marks the last. A non-periodic, too short
// or overlong string gives one result. Bytes are not accepted while the
// results of a string are being worked out. The memories need no clearing
// after reset: every entry is written in a run before it is read.
module string_period_finder import spf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  spf_sym_if.sink     sym_ch,
  spf_res_if.source   res_ch
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CMP       = 4'd1;
  localparam logic [3:0] S_LINK      = 4'd2;
  localparam logic [3:0] S_FIN       = 4'd3;
  localparam logic [3:0] S_CHK       = 4'd4;
  localparam logic [3:0] S_NEXT      = 4'd5;
  localparam logic [3:0] S_DIV       = 4'd6;
  localparam logic [3:0] S_EMIT_PEND = 4'd7;
  localparam logic [3:0] S_EMIT_LAST = 4'd8;

  logic [3:0] state;

  // run state
  logic [LEN_W-1:0] pos;
  logic [LEN_W-1:0] match_length;
  logic             too_long;

  // per-byte working registers
  logic [SYM_W-1:0] cur_sym;
  logic             cur_last;
  logic [LEN_W-1:0] j;

  // end-of-string search registers
  logic [LEN_W-1:0] n_reg;
  logic [LEN_W-1:0] lps_reg;
  logic             ovf;
  logic [LEN_W-1:0] p_reg;
  logic [LEN_W-1:0] d;
  logic [CNT_W-1:0] cnt;
  logic [PERIOD_W-1:0] pend_period;
  logic             pend_periodic;
  logic             pend_ovf;

  // output register
  logic                out_valid;
  logic                out_periodic;
  logic [PERIOD_W-1:0] out_period;
  logic                out_overflow;
  logic                out_final;

  // memories
  logic [SYM_W-1:0] text_mem   [MAX_LEN];
  logic [LEN_W-1:0] prefix_mem [MAX_LEN];
  logic [SYM_W-1:0] text_q;
  logic [LEN_W-1:0] prefix_q;
  logic [ADDR_W-1:0] text_raddr;
  logic [ADDR_W-1:0] prefix_raddr;
  logic              text_we;
  logic              prefix_we;
  logic [LEN_W-1:0]  prefix_wdata;

  logic             sym_accept;
  logic             store_full;
  logic             sym_eq;
  logic             chase;
  logic [LEN_W-1:0] j_next;
  logic [LEN_W-1:0] j_dec;
  logic [LEN_W-1:0] n_half;
  logic             out_free;
  logic             out_load;
  logic             fin_div;
  logic             next_div;

  div_req_t div_req;
  div_rsp_t div_rsp;

  spf_divrem u_divrem (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign sym_ch.ready = (state == S_IDLE);
  assign sym_accept   = sym_ch.valid && sym_ch.ready;
  assign store_full   = (pos == LEN_W'(MAX_LEN));

  assign sym_eq   = (text_q == cur_sym);
  assign chase    = !sym_eq && (j != '0);
  assign j_next   = j + LEN_W'(sym_eq);
  assign j_dec    = j - LEN_W'(1);
  assign n_half   = n_reg >> 1;
  assign out_free = !out_valid || res_ch.ready;
  assign out_load = ((state == S_EMIT_PEND) || (state == S_EMIT_LAST)) && out_free;

  assign fin_div  = (state == S_FIN) && !ovf && (n_reg >= LEN_W'(2)) && (lps_reg != '0);
  assign next_div = (state == S_NEXT) && (d <= n_half) &&
                    (cnt != CNT_W'(MAX_RESULTS));

  always_comb begin
    text_raddr   = (state == S_LINK) ? prefix_q[ADDR_W-1:0] : match_length[ADDR_W-1:0];
    prefix_raddr = j_dec[ADDR_W-1:0];
    text_we      = sym_accept && !store_full;
    prefix_we    = (sym_accept && !store_full && (pos == '0)) ||
                   ((state == S_CMP) && !chase);
    prefix_wdata = (state == S_CMP) ? j_next : '0;

    div_req.start    = fin_div || next_div;
    div_req.dividend = n_reg;
    div_req.divisor  = (state == S_FIN) ? (n_reg - lps_reg) : d;
  end

  // text memory: written on byte accept unless the store is full, read every cycle
  always_ff @(posedge clk) begin
    if (text_we) begin
      text_mem[pos[ADDR_W-1:0]] <= sym_ch.symbol;
    end
    text_q <= text_mem[text_raddr];
  end

  // prefix memory: entry for the current position written with zero for the first byte, else when the match settles
  always_ff @(posedge clk) begin
    if (prefix_we) begin
      prefix_mem[pos[ADDR_W-1:0]] <= prefix_wdata;
    end
    prefix_q <= prefix_mem[prefix_raddr];
  end

  // result valid: set on load, cleared once the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pos          <= '0;
      match_length <= '0;
      too_long     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (sym_accept) begin
            cur_sym  <= sym_ch.symbol;
            cur_last <= sym_ch.last;
            j        <= match_length;
            if (store_full) begin
              // byte dropped, run flagged overlong
              if (sym_ch.last) begin
                ovf          <= 1'b1;
                n_reg        <= pos;
                lps_reg      <= match_length;
                pos          <= '0;
                match_length <= '0;
                too_long     <= 1'b0;
                state        <= S_FIN;
              end else begin
                too_long <= 1'b1;
              end
            end else if (pos == '0) begin
              match_length <= '0;
              if (sym_ch.last) begin
                ovf          <= too_long;
                n_reg        <= LEN_W'(1);
                lps_reg      <= '0;
                pos          <= '0;
                too_long     <= 1'b0;
                state        <= S_FIN;
              end else begin
                pos <= LEN_W'(1);
              end
            end else begin
              // text read at match_length issued this cycle
              state <= S_CMP;
            end
          end
        end

        S_CMP: begin
          if (chase) begin
            state <= S_LINK;
          end else if (cur_last) begin
            ovf          <= too_long;
            n_reg        <= pos + LEN_W'(1);
            lps_reg      <= j_next;
            pos          <= '0;
            match_length <= '0;
            too_long     <= 1'b0;
            state        <= S_FIN;
          end else begin
            match_length <= j_next;
            pos          <= pos + LEN_W'(1);
            state        <= S_IDLE;
          end
        end

        S_LINK: begin
          // follow failure link; text read at the new length issued now
          j     <= prefix_q;
          state <= S_CMP;
        end

        S_FIN: begin
          pend_periodic <= 1'b0;
          pend_period   <= '0;
          pend_ovf      <= ovf;
          p_reg         <= n_reg - lps_reg;
          if (fin_div) begin
            state <= S_CHK;
          end else begin
            state <= S_EMIT_LAST;
          end
        end

        S_CHK: begin
          if (div_rsp.done) begin
            if (div_rsp.rem != '0) begin
              state <= S_EMIT_LAST;
            end else begin
              // p itself always qualifies: n/p is at least two
              pend_periodic <= 1'b1;
              pend_period   <= p_reg[PERIOD_W-1:0];
              cnt           <= CNT_W'(1);
              d             <= p_reg + p_reg;
              state         <= S_NEXT;
            end
          end
        end

        S_NEXT: begin
          if (next_div) begin
            state <= S_DIV;
          end else begin
            state <= S_EMIT_LAST;
          end
        end

        S_DIV: begin
          if (div_rsp.done) begin
            if (div_rsp.rem == '0) begin
              state <= S_EMIT_PEND;
            end else begin
              d     <= d + p_reg;
              state <= S_NEXT;
            end
          end
        end

        S_EMIT_PEND: begin
          // a further divisor found: the held one is not the last
          if (out_free) begin
            out_periodic <= pend_periodic;
            out_period   <= pend_period;
            out_overflow <= pend_ovf;
            out_final    <= 1'b0;
            pend_period  <= d[PERIOD_W-1:0];
            cnt          <= cnt + CNT_W'(1);
            d            <= d + p_reg;
            state        <= S_NEXT;
          end
        end

        S_EMIT_LAST: begin
          if (out_free) begin
            out_periodic <= pend_periodic;
            out_period   <= pend_period;
            out_overflow <= pend_ovf;
            out_final    <= 1'b1;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res_ch.valid     = out_valid;
  assign res_ch.periodic  = out_periodic;
  assign res_ch.period    = out_period;
  assign res_ch.overflow  = out_overflow;
  assign res_ch.final_res = out_final;

  // divider is only started when free
  a_div_start_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("remainder unit started while busy");

  // KMP invariant: matched length stays below the stored length
  a_match_below_pos: assert property (@(posedge clk) disable iff (rst)
    (pos != '0) |-> (match_length < pos))
    else $error("match length not below position");

  // only periodic strings give more than one result
  a_nonfinal_periodic: assert property (@(posedge clk) disable iff (rst)
    (res_ch.valid && !res_ch.final_res) |-> res_ch.periodic)
    else $error("non-final result that is not periodic");

  // bytes are taken only with the search finished
  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    sym_ch.ready |-> !div_rsp.busy)
    else $error("byte accepted during period search");

endmodule

// File: rtl/core/spf_divrem.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
// Depends on spf_pkg.
module spf_divrem import spf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] steps;
  logic [LEN_W-1:0]  dvd;
  logic [LEN_W-1:0]  dvs;
  logic [LEN_W-1:0]  rem;
  logic [LEN_W:0]    trial;
  logic [LEN_W:0]    diff;

  assign trial = {rem, dvd[LEN_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIV_STEPS);
        dvd   <= req.dividend;
        dvs   <= req.divisor;
        rem   <= '0;
      end else if (busy) begin
        // remainder stays below divisor, so it fits LEN_W bits
        rem   <= (trial >= {1'b0, dvs}) ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
        dvd   <= {dvd[LEN_W-2:0], 1'b0};
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule
